### src/circle_mask_rasterizer_macros.svh
// Assertion macros for the circle mask rasteriser.
`ifndef CIRCLE_MASK_RASTERIZER_MACROS_SVH
`define CIRCLE_MASK_RASTERIZER_MACROS_SVH

`ifndef SYNTH
`define CMR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define CMR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`else
`define CMR_ASSERT(lbl, prop, msg)
`define CMR_ASSERT_IMPL(lbl, ante, cons, msg)
`endif

`endif

### src/cmr_pkg.sv
// Types and constants of the circle mask rasteriser.
`timescale 1ns / 1ps

package cmr_pkg;

  localparam int unsigned RadW   = 7;
  localparam int unsigned CoordW = 8;
  localparam int unsigned AlphaW = 8;
  localparam int unsigned SqW    = 2 * RadW;
  localparam int unsigned D2W    = SqW + 1;

  localparam logic [RadW-1:0]   MAX_RADIUS   = 7'd96;
  localparam logic [AlphaW-1:0] ALPHA_OPAQUE = 8'd255;
  localparam logic [AlphaW-1:0] ALPHA_CLEAR  = 8'd0;

  // register index, paddr[3:2]
  localparam logic [1:0] REG_MASK_RADIUS   = 2'd0;
  localparam logic [1:0] REG_RING_MODE     = 2'd1;
  localparam logic [1:0] REG_QUADRANT_ONLY = 2'd2;

  typedef struct packed {
    logic              last_pixel;
    logic [AlphaW-1:0] alpha;
    logic [CoordW-1:0] row;
    logic [CoordW-1:0] column;
  } pix_t;

endpackage

### src/circle_mask_rasterizer.sv
// Disc, ring and corner alpha mask rasteriser, one pixel per item.
`timescale 1ns / 1ps
`include "circle_mask_rasterizer_macros.svh"

// channel   dir  payload
// s_axis    in   tdata[0] restart
// m_axis    out  tdata column,row,alpha; tlast last_pixel
// apb       in   mask_radius @0x0, ring_mode @0x4, quadrant_only @0x8
//
// One pixel per cycle while s_axis_tready is high: the scan position
// update, two 7x7 squares and the distance compare sit between the scan
// registers and the output register, which drives m_axis_tvalid. A
// two-entry output stage (register plus skid) keeps s_axis_tready high
// until the skid fills in a stall; s_axis_tready is registered.
// Reset: radius 1, filled, full square, scan at (0,0). No clearing pass.

module circle_mask_rasterizer
  import cmr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [0] restart
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] column, [15:8] row, [23:16] alpha
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [RadW-1:0]   radius_q, radius_d;
  logic [SqW-1:0]    rr_q, rr_d;
  logic [D2W-1:0]    rp1sq_q, rp1sq_d;
  logic              ring_q, quad_q;
  logic [CoordW-1:0] scan_col_q, scan_col_d, scan_row_q, scan_row_d;
  pix_t              out_q, skid_q, pix;
  logic              out_valid_q, skid_valid_q;

  logic              cfg_wr, in_acc, out_fire;
  logic [RadW-1:0]   wr_rad;
  logic [RadW:0]     rad_p1;
  logic [2*RadW+1:0] rad_p1_sq;
  logic [CoordW-1:0] side, side_m1;
  logic [CoordW-1:0] c0, r0, c1, r1, c2, r2;
  logic [CoordW:0]   dxs, dys, dxa, dya;
  logic [SqW-1:0]    sqx, sqy;
  logic [D2W-1:0]    d2;
  logic [D2W:0]      d2_plus;
  logic              opaque, last;

  // ---------------- configuration ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  assign wr_rad    = (pwdata[RadW-1:0] > MAX_RADIUS) ? MAX_RADIUS : pwdata[RadW-1:0];
  assign rad_p1    = {1'b0, wr_rad} + {{RadW{1'b0}}, 1'b1};
  assign rad_p1_sq = {{(RadW+1){1'b0}}, rad_p1} * {{(RadW+1){1'b0}}, rad_p1};

  always_comb begin
    radius_d = radius_q;
    rr_d     = rr_q;
    rp1sq_d  = rp1sq_q;
    if (cfg_wr && paddr[3:2] == REG_MASK_RADIUS) begin
      radius_d = wr_rad;
      rr_d     = {{RadW{1'b0}}, wr_rad} * {{RadW{1'b0}}, wr_rad};
      rp1sq_d  = rad_p1_sq[D2W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= 7'd1;
      rr_q     <= 14'd1;
      rp1sq_q  <= 15'd4;
      ring_q   <= 1'b0;
      quad_q   <= 1'b0;
    end else begin
      radius_q <= radius_d;
      rr_q     <= rr_d;
      rp1sq_q  <= rp1sq_d;
      if (cfg_wr && paddr[3:2] == REG_RING_MODE) begin
        ring_q <= pwdata[0];
      end
      if (cfg_wr && paddr[3:2] == REG_QUADRANT_ONLY) begin
        quad_q <= pwdata[0];
      end
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_MASK_RADIUS:   prdata = {25'd0, radius_q};
      REG_RING_MODE:     prdata = {31'd0, ring_q};
      REG_QUADRANT_ONLY: prdata = {31'd0, quad_q};
      default:           prdata = 32'd0;
    endcase
  end

  // ---------------- scan and pixel ----------------
  assign side_m1 = quad_q ? {1'b0, radius_q} : {radius_q, 1'b0};
  assign side    = side_m1 + 8'd1;

  always_comb begin
    c0 = s_axis_tdata[0] ? '0 : scan_col_q;
    r0 = s_axis_tdata[0] ? '0 : scan_row_q;
    if (c0 >= side) begin
      c1 = '0;
      r1 = r0 + 8'd1;
    end else begin
      c1 = c0;
      r1 = r0;
    end
    if (r1 >= side) begin
      c2 = '0;
      r2 = '0;
    end else begin
      c2 = c1;
      r2 = r1;
    end
  end

  assign last = (c2 == side_m1) && (r2 == side_m1);

  always_comb begin
    if (last) begin
      scan_col_d = '0;
      scan_row_d = '0;
    end else if (c2 == side_m1) begin
      scan_col_d = '0;
      scan_row_d = r2 + 8'd1;
    end else begin
      scan_col_d = c2 + 8'd1;
      scan_row_d = r2;
    end
  end

  // |col - r| and |row - r| serve both layouts
  assign dxs = {1'b0, c2} - {2'b0, radius_q};
  assign dys = {1'b0, r2} - {2'b0, radius_q};
  assign dxa = dxs[CoordW] ? (~dxs + 9'd1) : dxs;
  assign dya = dys[CoordW] ? (~dys + 9'd1) : dys;
  assign sqx = {{RadW{1'b0}}, dxa[RadW-1:0]} * {{RadW{1'b0}}, dxa[RadW-1:0]};
  assign sqy = {{RadW{1'b0}}, dya[RadW-1:0]} * {{RadW{1'b0}}, dya[RadW-1:0]};
  assign d2  = {1'b0, sqx} + {1'b0, sqy};
  assign d2_plus = {1'b0, d2} + {8'd0, radius_q, 1'b0};

  always_comb begin
    if (ring_q) begin
      opaque = (d2 <= rp1sq_q) && (d2_plus >= {2'b0, rr_q});
    end else begin
      opaque = d2 <= {1'b0, rr_q};
    end
  end

  assign pix.column     = c2;
  assign pix.row        = r2;
  assign pix.alpha      = opaque ? ALPHA_OPAQUE : ALPHA_CLEAR;
  assign pix.last_pixel = last;

  // ---------------- handshake ----------------
  assign s_axis_tready = ~skid_valid_q;
  assign in_acc        = s_axis_tvalid & s_axis_tready;
  assign out_fire      = out_valid_q & m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_col_q   <= '0;
      scan_row_q   <= '0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        scan_col_q <= scan_col_d;
        scan_row_q <= scan_row_d;
      end
      if (skid_valid_q) begin
        if (out_fire) begin
          skid_valid_q <= 1'b0;
        end
      end else if (in_acc) begin
        if (out_valid_q && !out_fire) begin
          skid_valid_q <= 1'b1;
        end else begin
          out_valid_q <= 1'b1;
        end
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else if (in_acc) begin
      if (out_valid_q && !out_fire) begin
        skid_q <= pix;
      end else begin
        out_q <= pix;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.alpha, out_q.row, out_q.column};
  assign m_axis_tlast  = out_q.last_pixel;

  // ---------------- checks ----------------
  `CMR_ASSERT_IMPL(a_skid_needs_out, skid_valid_q, out_valid_q, "skid full with output empty")
  `CMR_ASSERT_IMPL(a_out_in_square, out_valid_q,
                   (out_q.column < side) && (out_q.row < side), "pixel outside mask")
  `CMR_ASSERT_IMPL(a_last_corner, out_valid_q && out_q.last_pixel,
                   (out_q.column == side_m1) && (out_q.row == side_m1), "last pixel misplaced")
  `CMR_ASSERT(a_ready_follows_skid, s_axis_tready == !skid_valid_q, "ready out of step")

endmodule

### bench/circle_mask_checker.sv
// Pixel predictor and scoreboard that watches the circle mask rasteriser's channels.
`timescale 1ns / 1ps

module circle_mask_checker
  import cmr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [0] restart
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [23:0] m_axis_tdata,   // [7:0] column, [15:8] row, [23:16] alpha
  input  logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  output int unsigned mismatches_o,
  output int unsigned pixels_owed_o
);

  pix_t            pixels_due[$];
  int unsigned     fail_count = 0;
  int unsigned     owed_count = 0;
  logic [RadW-1:0] radius_q;
  logic            ring_q;
  logic            quad_q;
  int              scan_col;
  int              scan_row;

  assign mismatches_o  = fail_count;
  assign pixels_owed_o = owed_count;

  // next pixel of the scan; advances the scan position
  function automatic pix_t rasterise_pixel(input logic restart);
    int   r;
    int   side;
    int   col;
    int   row;
    int   dx;
    int   dy;
    int   d2;
    logic opaque;
    logic last;
    pix_t p;
    r    = int'(radius_q);
    side = quad_q ? r + 1 : 2 * r + 1;
    if (restart) begin
      scan_col = 0;
      scan_row = 0;
    end
    if (scan_col >= side) begin
      scan_col = 0;
      scan_row = scan_row + 1;
    end
    if (scan_row >= side) begin
      scan_col = 0;
      scan_row = 0;
    end
    col = scan_col;
    row = scan_row;
    if (quad_q) begin
      dx = r - col;
      dy = r - row;
    end else begin
      dx = col - r;
      dy = row - r;
    end
    d2 = dx * dx + dy * dy;
    if (ring_q) opaque = (d2 <= (r + 1) * (r + 1)) && (d2 >= r * r - 2 * r);
    else        opaque = (d2 <= r * r);
    last = (col == side - 1) && (row == side - 1);
    p.column     = col[CoordW-1:0];
    p.row        = row[CoordW-1:0];
    p.alpha      = opaque ? ALPHA_OPAQUE : ALPHA_CLEAR;
    p.last_pixel = last;
    if (last) begin
      scan_col = 0;
      scan_row = 0;
    end else if (col + 1 >= side) begin
      scan_col = 0;
      scan_row = row + 1;
    end else begin
      scan_col = col + 1;
    end
    return p;
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pix_t            want;
    pix_t            next_pix;
    logic [RadW-1:0] rad_w;
    if (!rst_ni) begin
      radius_q = RadW'(1);
      ring_q   = 1'b0;
      quad_q   = 1'b0;
      scan_col = 0;
      scan_row = 0;
      pixels_due.delete();
      owed_count <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pixels_due.size() == 0) begin
          $error("unexpected pixel: column %0d row %0d", m_axis_tdata[7:0], m_axis_tdata[15:8]);
          fail_count++;
        end else begin
          want = pixels_due.pop_front();
          check_field("column", 32'(want.column), 32'(m_axis_tdata[7:0]));
          check_field("row", 32'(want.row), 32'(m_axis_tdata[15:8]));
          check_field("alpha", 32'(want.alpha), 32'(m_axis_tdata[23:16]));
          check_field("last_pixel", 32'(want.last_pixel), 32'(m_axis_tlast));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        next_pix = rasterise_pixel(s_axis_tdata[0]);
        pixels_due.insert(pixels_due.size(), next_pix);
      end
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (paddr[3:2])
            REG_MASK_RADIUS: begin
              rad_w    = pwdata[RadW-1:0];
              radius_q = (rad_w > MAX_RADIUS) ? MAX_RADIUS : rad_w;
            end
            REG_RING_MODE:     ring_q = pwdata[0];
            REG_QUADRANT_ONLY: quad_q = pwdata[0];
            default: ;
          endcase
        end else begin
          case (paddr[3:2])
            REG_MASK_RADIUS:   check_field("mask_radius", {25'b0, radius_q}, prdata);
            REG_RING_MODE:     check_field("ring_mode", {31'b0, ring_q}, prdata);
            REG_QUADRANT_ONLY: check_field("quadrant_only", {31'b0, quad_q}, prdata);
            default: ;
          endcase
        end
      end
      owed_count <= pixels_due.size();
    end
  end

endmodule

### bench/testbench.sv
// Top of the circle mask rasteriser testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
  import cmr_pkg::*;

  localparam int unsigned CycleLimit  = 400_000;
  localparam int unsigned RandomItems = 500;

  logic        clk_i    = 1'b0;
  logic        rst_ni   = 1'b0;
  logic        s_tvalid = 1'b0;
  logic [7:0]  s_tdata  = '0;
  logic        s_tready;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic        m_tlast;
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [3:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;
  logic [31:0] prdata;
  logic        pready;

  int unsigned max_gap     = 11;
  int unsigned cycle_count = 0;
  int unsigned cur_side    = 3;
  int unsigned mismatches;
  int unsigned pixels_owed;

  circle_mask_rasterizer i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tlast  (m_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  circle_mask_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tlast  (m_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .mismatches_o  (mismatches),
    .pixels_owed_o (pixels_owed)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  // pixel sink with random stalls
  initial begin
    int unsigned stall;
    @(posedge clk_i);
    forever begin
      stall = $urandom_range(0, max_gap);
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_tready <= 1'b1;
      do @(posedge clk_i); while (!m_tvalid);
    end
  end

  task automatic apb_access(input logic wr, input logic [1:0] idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // wait until every pixel owed has left the block
  task automatic settle();
    @(posedge clk_i);
    while (pixels_owed != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic configure(input logic [RadW-1:0] rad_w, input logic ring, input logic quad);
    int unsigned r;
    settle();
    apb_access(1'b1, REG_MASK_RADIUS, ($urandom() & 32'hFFFF_FF80) | {25'b0, rad_w});
    apb_access(1'b1, REG_RING_MODE, ($urandom() & 32'hFFFF_FFFE) | {31'b0, ring});
    apb_access(1'b1, REG_QUADRANT_ONLY, ($urandom() & 32'hFFFF_FFFE) | {31'b0, quad});
    apb_access(1'b0, REG_MASK_RADIUS, '0);
    apb_access(1'b0, REG_RING_MODE, '0);
    apb_access(1'b0, REG_QUADRANT_ONLY, '0);
    r        = 32'((rad_w > MAX_RADIUS) ? MAX_RADIUS : rad_w);
    cur_side = quad ? r + 1 : 2 * r + 1;
  endtask

  task automatic push_pixel(input logic restart);
    int unsigned gap;
    gap = $urandom_range(0, max_gap);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'b0, restart};
    do @(posedge clk_i); while (!s_tready);
  endtask

  // n items; optional restart on the first, optional stray restarts
  task automatic push_run(input int unsigned n, input logic restart_first, input logic noise);
    for (int unsigned i = 0; i < n; i++)
      push_pixel((i == 0 && restart_first) || (noise && $urandom_range(0, 19) == 0));
    s_tvalid <= 1'b0;
  endtask

  initial begin
    int unsigned sent;
    int unsigned pick;
    int unsigned kind;
    int unsigned n;
    logic [RadW-1:0] rad;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values, then the default 3x3 disc and its wrap
    apb_access(1'b0, REG_MASK_RADIUS, '0);
    apb_access(1'b0, REG_RING_MODE, '0);
    apb_access(1'b0, REG_QUADRANT_ONLY, '0);
    push_run(10, 1'b0, 1'b0);
    // zero radius, filled and ring
    configure(7'd0, 1'b0, 1'b0);
    push_run(1, 1'b0, 1'b0);
    configure(7'd0, 1'b1, 1'b0);
    push_run(1, 1'b0, 1'b0);
    // radius saturates
    configure(7'd127, 1'b1, 1'b0);
    push_run(3, 1'b1, 1'b0);
    // corner quadrant, restart mid-scan
    configure(7'd3, 1'b0, 1'b1);
    push_run(2, 1'b1, 1'b0);
    push_run(2, 1'b1, 1'b0);
    // shrink leaves the column past the edge, then the row past the edge
    configure(7'd2, 1'b0, 1'b0);
    push_run(9, 1'b1, 1'b0);
    configure(7'd1, 1'b1, 1'b0);
    push_run(1, 1'b0, 1'b0);
    configure(7'd0, 1'b0, 1'b0);
    push_run(1, 1'b0, 1'b0);

    sent = 0;
    while (sent < RandomItems) begin
      pick = $urandom_range(0, 9);
      if (pick < 6)       rad = RadW'($urandom_range(0, 6));
      else if (pick < 8)  rad = RadW'($urandom_range(7, 20));
      else if (pick == 8) rad = RadW'($urandom_range(96, 127));
      else                rad = RadW'($urandom_range(0, 127));
      configure(rad, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      max_gap = ($urandom_range(0, 3) == 0) ? 0 : 11;
      kind = $urandom_range(0, 9);
      if (kind < 7 && cur_side * cur_side <= 400) begin
        n = cur_side * cur_side;
        push_run(n, 1'b1, 1'b0);
      end else begin
        if (cur_side > 20 && $urandom_range(0, 1) == 1) n = cur_side + 4;
        else                                            n = $urandom_range(5, 60);
        push_run(n, kind < 7, 1'b1);
      end
      sent += n;
    end

    settle();
    if (mismatches == 0 && pixels_owed == 0) $display("tb: success");
    else                                      $display("tb: failure");
    $finish;
  end

endmodule

### filelist.f
+incdir+src
src/cmr_pkg.sv
src/circle_mask_rasterizer.sv
bench/circle_mask_checker.sv
bench/testbench.sv
